// ----- rtl/bkc_pkg.sv -----
// Shared types and constants of the per-candidate best-kind classifier.
// No dependencies; every other file of the block imports this package.
package bkc_pkg;

   localparam int SCORE_W  = 16;
   localparam int ID_WIDTH = 14;
   localparam int CSR_W    = 16;
   localparam int RANK_W   = SCORE_W + 2;
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef score_type [2:0] best_set_type;

   localparam score_type BEST_RESET = score_type'(-256);
   localparam logic signed [RANK_W-1:0] RANK_FLOOR = RANK_W'(-512);

   typedef enum logic [1:0] {
      CLASS_MALE    = 2'd0,
      CLASS_FEMALE  = 2'd1,
      CLASS_FERRULE = 2'd2,
      CLASS_UNKNOWN = 2'd3
   } kind_type;

   // kind code 3 on a request means the score is not merged
   localparam kind_type KIND_IGNORED = CLASS_UNKNOWN;

   typedef enum logic [1:0] {
      REG_MF_THRESH  = 2'd0,
      REG_FER_THRESH = 2'd1,
      REG_MARGIN     = 2'd2,
      REG_SPARE      = 2'd3
   } reg_index_type;

   typedef struct packed {
      score_type           score;
      kind_type            kind;
      logic [ID_WIDTH-1:0] cand;
      logic                last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic room_for_two;
   } queue_status_type;

endpackage

// ----- rtl/bkc_rank.sv -----
// Ranks the three per-kind bests of one candidate and labels the winner.
// Uses bkc_pkg; instantiated twice by the top level.
module bkc_rank (
   input  bkc_pkg::best_set_type      bests,
   input  logic [bkc_pkg::CSR_W-1:0]  mf_thresh,
   input  logic [bkc_pkg::CSR_W-1:0]  fer_thresh,
   input  logic [bkc_pkg::CSR_W-1:0]  margin,
   output bkc_pkg::score_type         top_score,
   output bkc_pkg::kind_type          class_kind
);
   import bkc_pkg::*;

   logic signed [RANK_W-1:0] top1;
   logic signed [RANK_W-1:0] top2;
   logic signed [RANK_W-1:0] cur;
   logic signed [RANK_W-1:0] need;
   logic signed [RANK_W-1:0] lead;
   kind_type                 win;

   always_comb begin
      top1 = RANK_FLOOR;
      top2 = RANK_FLOOR;
      win  = CLASS_UNKNOWN;
      for (int k = 0; k < 3; k++) begin
         cur = RANK_W'(bests[k]);
         if (cur > top1) begin
            top2 = top1;
            top1 = cur;
            win  = kind_type'(k[1:0]);
         end else if (cur > top2) begin
            top2 = cur;
         end
      end
      need = (win == CLASS_FERRULE) ? $signed({2'b00, fer_thresh})
                                    : $signed({2'b00, mf_thresh});
      lead = top1 - top2;
      if (top1 < need || lead < $signed({2'b00, margin})) begin
         class_kind = CLASS_UNKNOWN;
      end else begin
         class_kind = win;
      end
      top_score = top1[SCORE_W-1:0];
   end

endmodule

// ----- rtl/bkc_queue.sv -----
// Four-entry result queue; takes up to two results a cycle, gives one.
// Uses bkc_pkg.
module bkc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  bkc_pkg::push_type         push_a,
   input  bkc_pkg::push_type         push_b,
   input  logic                      pop,
   output bkc_pkg::result_type       head,
   output bkc_pkg::queue_status_type status
);
   import bkc_pkg::*;

   result_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QPTR_W-1:0]   b_addr;

   always_comb begin
      b_addr    = wr_ptr_ff + QPTR_W'(push_a.valid);
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_a.valid) + QPTR_W'(push_b.valid);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_a.valid) + QCNT_W'(push_b.valid)
                  - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a.valid) begin
         mem_ff[wr_ptr_ff] <= push_a.data;
      end
      if (push_b.valid) begin
         mem_ff[b_addr] <= push_b.data;
      end
   end

   assign head                = mem_ff[rd_ptr_ff];
   assign status.not_empty    = (count_ff != '0);
   assign status.room_for_two = (count_ff <= QCNT_W'(QDEPTH - 2));

endmodule

// ----- rtl/per_candidate_best_kind_classifier.sv -----
// Per-candidate best-kind classifier: top level with state, config and handshakes.
// Uses bkc_pkg, bkc_rank and bkc_queue.
//
// One request is taken per clock while req_stall is low. A request that closes
// the open candidate (new id) and/or ends the batch yields one or two results,
// labelled in the cycle of acceptance and shown on rsp_* behind any results
// already queued. Results leave one per clock while rsp_stall is low, through
// a four-entry queue; req_stall rises while fewer than two entries are free,
// so two-result requests in a run are paced by the single output port.
module per_candidate_best_kind_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [15:0]             req_match_score,
   input  logic [1:0]                     req_score_kind,
   input  logic [bkc_pkg::ID_WIDTH-1:0]   req_candidate_id,
   input  logic                           req_batch_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [15:0]             rsp_top_score,
   output logic [1:0]                     rsp_class_kind,
   output logic [bkc_pkg::ID_WIDTH-1:0]   rsp_result_candidate,
   output logic                           rsp_result_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [15:0]                    csr_wdata
);
   import bkc_pkg::*;

   logic [CSR_W-1:0]    mf_thresh_ff, fer_thresh_ff, margin_ff;
   best_set_type        best_ff, best_in;
   logic [ID_WIDTH-1:0] open_id_ff, open_id_in;
   logic                open_ff, open_in;

   logic                req_take;
   logic                rsp_take;
   logic                flush;
   kind_type            in_kind;
   best_set_type        base;
   best_set_type        merged;
   score_type           old_score, new_score;
   kind_type            old_kind, new_kind;
   push_type            push_a, push_b;
   result_type          head;
   queue_status_type    qstat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mf_thresh_ff  <= '0;
         fer_thresh_ff <= '0;
         margin_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_MF_THRESH:  mf_thresh_ff  <= csr_wdata;
            REG_FER_THRESH: fer_thresh_ff <= csr_wdata;
            REG_MARGIN:     margin_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign in_kind  = kind_type'(req_score_kind);
   assign flush    = open_ff && (req_candidate_id != open_id_ff);

   always_comb begin
      base = flush ? {3{BEST_RESET}} : best_ff;
      merged = base;
      if (in_kind != KIND_IGNORED && req_match_score > base[req_score_kind]) begin
         merged[req_score_kind] = req_match_score;
      end
      if (req_batch_end) begin
         best_in = {3{BEST_RESET}};
         open_in = 1'b0;
      end else begin
         best_in = merged;
         open_in = 1'b1;
      end
      open_id_in = req_candidate_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff    <= {3{BEST_RESET}};
         open_id_ff <= '0;
         open_ff    <= 1'b0;
      end else if (req_take) begin
         best_ff    <= best_in;
         open_id_ff <= open_id_in;
         open_ff    <= open_in;
      end
   end

   bkc_rank u_rank_old (
      .bests      (best_ff),
      .mf_thresh  (mf_thresh_ff),
      .fer_thresh (fer_thresh_ff),
      .margin     (margin_ff),
      .top_score  (old_score),
      .class_kind (old_kind)
   );

   bkc_rank u_rank_new (
      .bests      (merged),
      .mf_thresh  (mf_thresh_ff),
      .fer_thresh (fer_thresh_ff),
      .margin     (margin_ff),
      .top_score  (new_score),
      .class_kind (new_kind)
   );

   always_comb begin
      push_a.valid      = req_take && flush;
      push_a.data.score = old_score;
      push_a.data.kind  = old_kind;
      push_a.data.cand  = open_id_ff;
      push_a.data.last  = 1'b0;
      push_b.valid      = req_take && req_batch_end;
      push_b.data.score = new_score;
      push_b.data.kind  = new_kind;
      push_b.data.cand  = req_candidate_id;
      push_b.data.last  = 1'b1;
   end

   bkc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_a (push_a),
      .push_b (push_b),
      .pop    (rsp_take),
      .head   (head),
      .status (qstat)
   );

   assign req_stall            = !qstat.room_for_two;
   assign rsp_valid            = qstat.not_empty;
   assign rsp_top_score        = head.score;
   assign rsp_class_kind       = head.kind;
   assign rsp_result_candidate = head.cand;
   assign rsp_result_last      = head.last;

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      req_take && req_batch_end |=> !open_ff)
      else $error("candidate still open after batch end");

   a_flush_result: assert property (@(posedge clock) disable iff (reset)
      req_take && flush |=> rsp_valid)
      else $error("closed candidate produced no result");

   a_idle_bests: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (best_ff[0] == BEST_RESET && best_ff[1] == BEST_RESET &&
                    best_ff[2] == BEST_RESET))
      else $error("bests not cleared while no candidate is open");

endmodule

// ----- sim/bkc_result_checker.sv -----
// Result checker for the best-kind classifier testbench: watches the request,
// result and register channels, predicts every result and compares it field by field.
// Depends on bkc_pkg; instantiated beside the block by tb_per_candidate_best_kind_classifier.
module bkc_result_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [15:0]            req_match_score,
   input  logic [1:0]                    req_score_kind,
   input  logic [bkc_pkg::ID_WIDTH-1:0]  req_candidate_id,
   input  logic                          req_batch_end,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [15:0]            rsp_top_score,
   input  logic [1:0]                    rsp_class_kind,
   input  logic [bkc_pkg::ID_WIDTH-1:0]  rsp_result_candidate,
   input  logic                          rsp_result_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_wdata,
   output int                            mismatches,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bkc_pkg::*;

   score_type           best_of_kind [3];
   logic [ID_WIDTH-1:0] open_id;
   logic                open_flag;
   logic [CSR_W-1:0]    mf_thresh;
   logic [CSR_W-1:0]    fer_thresh;
   logic [CSR_W-1:0]    lead_needed;
   result_type          labels_due [$];
   result_type          want;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic clear_bests();
      foreach (best_of_kind[k]) best_of_kind[k] = BEST_RESET;
   endtask

   // rank the three bests; ties go to the lower kind and count as second best
   function automatic result_type label_candidate(input logic [ID_WIDTH-1:0] id,
                                                  input logic last_flag);
      int         top1;
      int         top2;
      int         need;
      kind_type   winner;
      result_type r;
      top1   = -512;
      top2   = -512;
      winner = CLASS_UNKNOWN;
      for (int k = 0; k < 3; k++) begin
         if (int'(best_of_kind[k]) > top1) begin
            top2   = top1;
            top1   = int'(best_of_kind[k]);
            winner = kind_type'(k);
         end else if (int'(best_of_kind[k]) > top2) begin
            top2 = int'(best_of_kind[k]);
         end
      end
      need = (winner == CLASS_FERRULE) ? int'(fer_thresh) : int'(mf_thresh);
      r.score = score_type'(top1);
      r.kind  = (top1 < need || (top1 - top2) < int'(lead_needed)) ? CLASS_UNKNOWN : winner;
      r.cand  = id;
      r.last  = last_flag;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         labels_due.delete();
         clear_bests();
         open_id     = '0;
         open_flag   = 1'b0;
         mf_thresh   = '0;
         fer_thresh  = '0;
         lead_needed = '0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (labels_due.size() == 0) begin
               report_mismatch($sformatf("result for candidate %0d with none expected",
                                         rsp_result_candidate));
            end else begin
               want = labels_due.pop_front();
               if (rsp_top_score !== want.score)
                  report_mismatch($sformatf("candidate %0d: top_score %0d, expected %0d",
                                            want.cand, rsp_top_score, want.score));
               if (rsp_class_kind !== want.kind)
                  report_mismatch($sformatf("candidate %0d: class_kind %0d, expected %0d",
                                            want.cand, rsp_class_kind, want.kind));
               if (rsp_result_candidate !== want.cand)
                  report_mismatch($sformatf("result_candidate %0d, expected %0d",
                                            rsp_result_candidate, want.cand));
               if (rsp_result_last !== want.last)
                  report_mismatch($sformatf("candidate %0d: result_last %0b, expected %0b",
                                            want.cand, rsp_result_last, want.last));
            end
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            case (csr_index)
               REG_MF_THRESH:  mf_thresh   = csr_wdata;
               REG_FER_THRESH: fer_thresh  = csr_wdata;
               REG_MARGIN:     lead_needed = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            // flush the old candidate before merging the new request
            if (open_flag && req_candidate_id != open_id) begin
               labels_due.push_back(label_candidate(open_id, 1'b0));
               clear_bests();
            end
            if (req_score_kind != KIND_IGNORED && req_match_score > best_of_kind[req_score_kind])
               best_of_kind[req_score_kind] = req_match_score;
            open_id   = req_candidate_id;
            open_flag = 1'b1;
            if (req_batch_end) begin
               labels_due.push_back(label_candidate(req_candidate_id, 1'b1));
               clear_bests();
               open_flag = 1'b0;
            end
         end
      end
      pending <= labels_due.size();
   end

endmodule

// ----- sim/tb_per_candidate_best_kind_classifier.sv -----
// Testbench top for per_candidate_best_kind_classifier: clock, reset, register writes,
// directed and random request streams with bursty sending and result back-pressure.
// Depends on bkc_pkg, the block's RTL and bkc_result_checker, which checks every result.
module tb_per_candidate_best_kind_classifier;
   timeunit 1ns;
   timeprecision 1ps;
   import bkc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 125;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 8;

   typedef enum int {PACE_FLOW, PACE_LIGHT, PACE_HEAVY, PACE_TOGGLE} pace_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [15:0]    req_match_score = '0;
   logic [1:0]            req_score_kind = '0;
   logic [ID_WIDTH-1:0]   req_candidate_id = '0;
   logic                  req_batch_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [15:0]    rsp_top_score;
   logic [1:0]            rsp_class_kind;
   logic [ID_WIDTH-1:0]   rsp_result_candidate;
   logic                  rsp_result_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [15:0]           csr_wdata = '0;
   int                    mismatches;
   int                    pending;
   int                    cycles = 0;
   int                    burst_left = 0;
   bit                    rsp_hold_asked = 1'b0;

   per_candidate_best_kind_classifier dut (.*);
   bkc_result_checker result_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_per_candidate_best_kind_classifier failed");
         $finish;
      end
   end

   // result back-pressure: random stretches of one pace, plus a long hold on request
   initial begin
      int       span;
      pace_type pace;
      forever begin
         span = $urandom_range(200, 20);
         pace = pace_type'($urandom_range(3, 0));
         repeat (span) begin
            @(posedge clock);
            if (rsp_hold_asked) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               rsp_hold_asked = 1'b0;
            end
            case (pace)
               PACE_FLOW:  rsp_stall <= 1'b0;
               PACE_LIGHT: rsp_stall <= ($urandom_range(3, 0) == 0);
               PACE_HEAVY: rsp_stall <= ($urandom_range(3, 0) != 0);
               default:    rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   task automatic send_item(input score_type score, input logic [1:0] kind,
                            input logic [ID_WIDTH-1:0] id, input logic last);
      int gap;
      req_match_score  <= score;
      req_score_kind   <= kind;
      req_candidate_id <= id;
      req_batch_end    <= last;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 40)
                                                  : $urandom_range(16, 0);
         gap = $urandom_range(8, 0);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_thresholds(input logic [15:0] mf, input logic [15:0] fer,
                                  input logic [15:0] lead);
      write_reg(REG_MF_THRESH, mf);
      write_reg(REG_FER_THRESH, fer);
      write_reg(REG_MARGIN, lead);
   endtask

   function automatic score_type pick_score();
      int roll;
      roll = $urandom_range(9, 0);
      if (roll == 0) return score_type'(-32768);
      if (roll == 1) return score_type'(32767);
      if (roll < 5) return score_type'($urandom());
      return score_type'(int'($urandom_range(1024, 0)) - 512);
   endfunction

   task automatic send_candidate(input logic [ID_WIDTH-1:0] id, input bit ends,
                                 inout int count);
      int         len;
      logic [1:0] kind;
      len = $urandom_range(5, 1);
      for (int i = 0; i < len; i++) begin
         kind = ($urandom_range(7, 0) == 0) ? KIND_IGNORED : 2'($urandom_range(2, 0));
         send_item(pick_score(), kind, id, ends && i == len - 1);
      end
      count += len;
   endtask

   initial begin
      logic [ID_WIDTH-1:0] id;
      logic [ID_WIDTH-1:0] prev_id;
      int                  sent;
      prev_id = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of score, single-kind wins, ignored-only candidate, ties, id extremes
      send_item(score_type'(32767), CLASS_MALE, 14'd0, 1'b0);
      send_item(score_type'(-32768), CLASS_FEMALE, 14'd0, 1'b0);
      send_item(score_type'(0), CLASS_FERRULE, 14'd0, 1'b1);
      send_item(score_type'(1000), KIND_IGNORED, 14'd5, 1'b1);
      send_item(score_type'(200), CLASS_MALE, 14'd7, 1'b0);
      send_item(score_type'(200), CLASS_FEMALE, 14'd7, 1'b0);
      send_item(score_type'(-1000), CLASS_FERRULE, 14'h3FFF, 1'b0);
      send_item(score_type'(-32768), KIND_IGNORED, 14'h3FFF, 1'b0);
      send_item(score_type'(300), CLASS_FERRULE, 14'h2AAA, 1'b1);
      send_item(score_type'(5), CLASS_FEMALE, 14'h1555, 1'b0);
      drain();

      // thresholds and margin in force; the spare index must change nothing
      write_reg(REG_SPARE, 16'hFFFF);
      load_thresholds(16'h0100, 16'hFFFF, 16'h0080);
      send_item(score_type'(16'h0100), CLASS_MALE, 14'h1555, 1'b0);
      send_item(score_type'(32767), CLASS_FERRULE, 14'd1, 1'b0);
      send_item(score_type'(0), KIND_IGNORED, 14'd1, 1'b1);
      send_item(score_type'(16'h0150), CLASS_MALE, 14'd2, 1'b0);
      send_item(score_type'(16'h0100), CLASS_FEMALE, 14'd2, 1'b1);
      send_item(score_type'(16'h0200), CLASS_FEMALE, 14'd3, 1'b0);
      send_item(score_type'(16'h0200), CLASS_MALE, 14'd3, 1'b1);
      send_item(score_type'(16'h0300), CLASS_MALE, 14'd9, 1'b1);
      send_item(score_type'(16'h00FF), CLASS_FEMALE, 14'd9, 1'b1);
      drain();
      write_reg(REG_MARGIN, 16'hFFFF);
      send_item(score_type'(32767), CLASS_FERRULE, 14'd4, 1'b1);
      send_item(score_type'(-300), CLASS_MALE, 14'd4, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0:       load_thresholds(16'h0000, 16'h0000, 16'h0000);
            1:       load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
            3:       load_thresholds(16'h0000, 16'hFFFF, 16'h0000);
            4:       load_thresholds(16'($urandom()), 16'($urandom()), 16'($urandom()));
            default: load_thresholds(16'($urandom_range(512, 0)), 16'($urandom_range(512, 0)),
                                     16'($urandom_range(256, 0)));
         endcase

         if (phase == 2) begin
            // long result hold while requests keep coming, then wait for all results
            rsp_hold_asked = 1'b1;
            for (int i = 0; i < 16; i++)
               send_item(pick_score(), 2'($urandom_range(2, 0)), ID_WIDTH'(1000 + i),
                         (i % 4) == 3);
            drain();
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(9, 0) == 0) begin
               send_item(pick_score(), 2'($urandom()),
                         $urandom_range(1, 0) ? prev_id : ID_WIDTH'($urandom()),
                         1'($urandom()));
               sent++;
            end else begin
               id = ($urandom_range(7, 0) == 0) ? prev_id : ID_WIDTH'($urandom());
               send_candidate(id, $urandom_range(3, 0) == 0, sent);
               prev_id = id;
            end
         end
      end

      // close whatever candidate is still open
      send_item(pick_score(), CLASS_MALE, ~prev_id, 1'b1);
      drain();
      if (mismatches == 0) begin
         $display("tb_per_candidate_best_kind_classifier passed");
      end else begin
         $display("tb_per_candidate_best_kind_classifier failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/bkc_pkg.sv
rtl/bkc_rank.sv
rtl/bkc_queue.sv
rtl/per_candidate_best_kind_classifier.sv
sim/bkc_result_checker.sv
sim/tb_per_candidate_best_kind_classifier.sv
